>>> rtl/core/xtea_pkg.sv
package xtea_pkg;

   localparam int ROUNDS     = 32;
   localparam int STAGES     = 2 * ROUNDS;
   localparam int WORD_W     = 32;
   localparam int KEY_WORDS  = 4;
   localparam int KEY_IDX_W  = $clog2(KEY_WORDS);
   localparam int OCC_W      = $clog2(STAGES + 1);
   localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [KEY_WORDS-1:0] key_type;

   typedef struct packed {
      logic     mode;
      word_type block_first;
      word_type block_second;
   } req_payload_type;

   typedef struct packed {
      word_type result_first;
      word_type result_second;
   } rsp_payload_type;

   typedef struct packed {
      logic     mode;
      word_type a;
      word_type b;
   } stage_data_type;

   typedef struct packed {
      word_type acc_enc;
      word_type acc_dec;
      logic     odd;
   } stage_ctl_type;

   function automatic word_type mix(input word_type x);
      return ((x << 4) ^ (x >> 5)) + x;
   endfunction

   function automatic word_type delta_times(input int k);
      logic [2*WORD_W-1:0] p;
      p = (2*WORD_W)'(k) * (2*WORD_W)'(DELTA);
      return p[WORD_W-1:0];
   endfunction

   function automatic stage_ctl_type stage_ctl(input int stage);
      stage_ctl_type c;
      int            k;
      k         = (stage + 1) >> 1;
      c.acc_enc = delta_times(k);
      c.acc_dec = delta_times(ROUNDS - k);
      c.odd     = 1'(stage & 1);
      return c;
   endfunction

endpackage

>>> rtl/core/xtea_stage.sv
module xtea_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  xtea_pkg::stage_ctl_type ctl,
   input  xtea_pkg::key_type       key,
   input  logic                    in_valid,
   input  xtea_pkg::stage_data_type in_data,
   output logic                    out_valid,
   output xtea_pkg::stage_data_type out_data
);
   import xtea_pkg::*;

   logic           valid_ff;
   stage_data_type data_ff;
   stage_data_type data_in;
   logic           upd_a;
   word_type       acc;
   logic [KEY_IDX_W-1:0] idx;
   word_type       other;
   word_type       target;
   word_type       f;
   word_type       updated;

   always_comb begin
      upd_a   = (in_data.mode == ctl.odd);
      acc     = in_data.mode ? ctl.acc_dec : ctl.acc_enc;
      idx     = upd_a ? acc[KEY_IDX_W-1:0] : acc[11 +: KEY_IDX_W];
      other   = upd_a ? in_data.b : in_data.a;
      target  = upd_a ? in_data.a : in_data.b;
      f       = mix(other) ^ (acc + key[idx]);
      updated = in_data.mode ? (target - f) : (target + f);
      data_in = in_data;
      if (upd_a) begin
         data_in.a = updated;
      end else begin
         data_in.b = updated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/core/xtea_block_cipher_top.sv
// One half-round per register stage.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// last stage's result waits on rsp_ready.
// Reset: synchronous, active high; clears stage valid bits and the key words.
module xtea_block_cipher_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  xtea_pkg::req_payload_type             req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output xtea_pkg::rsp_payload_type             rsp_payload,
   input  logic                                  csr_write_enable,
   input  logic [xtea_pkg::KEY_IDX_W-1:0]        csr_index,
   input  logic [xtea_pkg::WORD_W-1:0]           csr_write_data
);
   import xtea_pkg::*;

   key_type            key_ff;
   logic               advance;
   logic [STAGES-1:0]  stage_valid;
   stage_data_type     stage_data [STAGES];
   stage_data_type     entry_data;
   logic [OCC_W-1:0]   occ_ff;
   logic [OCC_W-1:0]   occ_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write_enable) begin
         key_ff[csr_index] <= csr_write_data;
      end
   end

   assign advance   = !stage_valid[STAGES-1] || rsp_ready;
   assign req_ready = advance;

   assign entry_data.mode = req_payload.mode;
   assign entry_data.a    = req_payload.block_first;
   assign entry_data.b    = req_payload.block_second;

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      if (g == 0) begin : g_first
         xtea_stage u_stage (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .ctl      (stage_ctl(g)),
            .key      (key_ff),
            .in_valid (req_valid),
            .in_data  (entry_data),
            .out_valid(stage_valid[g]),
            .out_data (stage_data[g])
         );
      end else begin : g_next
         xtea_stage u_stage (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .ctl      (stage_ctl(g)),
            .key      (key_ff),
            .in_valid (stage_valid[g-1]),
            .in_data  (stage_data[g-1]),
            .out_valid(stage_valid[g]),
            .out_data (stage_data[g])
         );
      end
   end

   assign rsp_valid                 = stage_valid[STAGES-1];
   assign rsp_payload.result_first  = stage_data[STAGES-1].a;
   assign rsp_payload.result_second = stage_data[STAGES-1].b;

   always_comb begin
      occ_in = occ_ff;
      if (req_valid && req_ready) begin
         occ_in = occ_in + OCC_W'(1);
      end
      if (rsp_valid && rsp_ready) begin
         occ_in = occ_in - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   a_occ_matches: assert property (@(posedge clock) disable iff (reset)
      occ_ff == OCC_W'($countones(stage_valid)))
      else $error("in-flight count disagrees with stage valid bits");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(STAGES))
      else $error("in-flight count above pipeline depth");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stage_valid))
      else $error("pipeline moved during stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (stage_valid == '0) && (occ_ff == '0))
      else $error("pipeline not empty after reset");

endmodule
